// ===== hdl/psd_pkg.sv =====
// Shared types and constants for the PID step with settle detection.
package psd_pkg;

   localparam int ERR_W    = 24;   // error sample, signed Q16.8
   localparam int DIFF_W   = 25;   // error difference
   localparam int ACC_W    = 40;   // integral sum, signed Q32.8
   localparam int ACC_LO_W = 20;   // lower slice of the integral for the split multiply
   localparam int GAIN_W   = 16;   // gains, unsigned Q8.8
   localparam int BAND_W   = 23;   // gate and settle band
   localparam int MS_W     = 16;   // settle limit and timeout
   localparam int TIMER_W  = 17;   // settle and run timers
   localparam int DRIVE_W  = 16;   // drive, signed Q8.8
   localparam int SUM_W    = 58;   // full controller sum, Q.16
   localparam int FRAC_W   = 8;    // bits dropped from the sum
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT = 16'sd25600;
   localparam logic [TIMER_W-1:0]        TIMER_MAX   = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P        = 3'd0,
      REG_GAIN_I        = 3'd1,
      REG_GAIN_D        = 3'd2,
      REG_INTEGRAL_GATE = 3'd3,
      REG_SETTLE_BAND   = 3'd4,
      REG_SETTLE_LIMIT  = 3'd5,
      REG_TIMEOUT       = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [BAND_W-1:0] integral_gate;
      logic [BAND_W-1:0] settle_band;
      logic [MS_W-1:0]   settle_limit_ms;
      logic [MS_W-1:0]   timeout_ms;
   } cfg_type;

   // Front stage result handed to the arithmetic pipe
   typedef struct packed {
      logic signed [ERR_W-1:0]  error;
      logic signed [DIFF_W-1:0] diff;
      logic signed [ACC_W-1:0]  acc;
      logic                     settled;
   } front_data_type;

endpackage

// ===== hdl/psd_if.sv =====
// Request, response and register write channel interfaces.
interface psd_req_if;
   import psd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [ERR_W-1:0] error_in;
   logic                    clear;
   modport source (output valid, output error_in, output clear, input ready);
   modport sink   (input valid, input error_in, input clear, output ready);
endinterface

interface psd_rsp_if;
   import psd_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;
   logic                      settled;
   modport source (output valid, output drive, output settled, input ready);
   modport sink   (input valid, input drive, input settled, output ready);
endinterface

interface psd_csr_if;
   import psd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/psd_csr.sv =====
// Configuration register bank.
module psd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_valid,
   input  logic [psd_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [psd_pkg::CSR_DATA_W-1:0] wr_data,
   output logic                          wr_ready,
   output psd_pkg::cfg_type              cfg
);
   import psd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            REG_GAIN_P:        cfg_in.gain_p          = wr_data[GAIN_W-1:0];
            REG_GAIN_I:        cfg_in.gain_i          = wr_data[GAIN_W-1:0];
            REG_GAIN_D:        cfg_in.gain_d          = wr_data[GAIN_W-1:0];
            REG_INTEGRAL_GATE: cfg_in.integral_gate   = wr_data[BAND_W-1:0];
            REG_SETTLE_BAND:   cfg_in.settle_band     = wr_data[BAND_W-1:0];
            REG_SETTLE_LIMIT:  cfg_in.settle_limit_ms = wr_data[MS_W-1:0];
            REG_TIMEOUT:       cfg_in.timeout_ms      = wr_data[MS_W-1:0];
            default:           cfg_in = cfg_ff;   // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/psd_front.sv =====
// Controller state update and first pipeline register.
module psd_front #(
   parameter int TICK_MS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  psd_pkg::cfg_type               cfg,
   input  logic                           in_valid,
   input  logic signed [psd_pkg::ERR_W-1:0] error_in,
   input  logic                           clear,
   output logic                           in_ready,
   output logic                           out_valid,
   output psd_pkg::front_data_type        out_data,
   input  logic                           out_ready
);
   import psd_pkg::*;

   localparam logic [TIMER_W:0] TICK = (TIMER_W+1)'(TICK_MS);

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ERR_W-1:0] last_ff, last_in;
   logic [TIMER_W-1:0]      settle_t_ff, settle_t_in;
   logic [TIMER_W-1:0]      run_t_ff, run_t_in;
   logic                    valid_ff;
   front_data_type          data_ff, data_in;

   logic                    accept;
   logic signed [ACC_W-1:0] acc_base;
   logic signed [ERR_W-1:0] last_base;
   logic [TIMER_W-1:0]      settle_base, run_base;
   logic [ERR_W-1:0]        mag;
   logic [ACC_W:0]          acc_sum;
   logic [TIMER_W:0]        settle_sum, run_sum;
   logic                    crossing;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      acc_base    = clear ? '0 : acc_ff;
      last_base   = clear ? '0 : last_ff;
      settle_base = clear ? '0 : settle_t_ff;
      run_base    = clear ? '0 : run_t_ff;

      mag = error_in[ERR_W-1] ? ERR_W'(-error_in) : ERR_W'(error_in);

      // gated accumulate, saturating on overflow of the 40-bit integral
      acc_sum = {acc_base[ACC_W-1], acc_base}
              + {{(ACC_W+1-ERR_W){error_in[ERR_W-1]}}, error_in};
      acc_in  = acc_base;
      if (mag < {1'b0, cfg.integral_gate}) begin
         if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_in = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                    : {1'b0, {(ACC_W-1){1'b1}}};
         end else begin
            acc_in = acc_sum[ACC_W-1:0];
         end
      end

      // sign change against previous sample; zero is no crossing
      crossing = (!error_in[ERR_W-1] && (error_in != '0) && last_base[ERR_W-1]) ||
                 (error_in[ERR_W-1] && !last_base[ERR_W-1] && (last_base != '0));
      if (crossing) begin
         acc_in = '0;
      end

      last_in = error_in;

      settle_sum = {1'b0, settle_base} + TICK;
      run_sum    = {1'b0, run_base} + TICK;
      if (mag < {1'b0, cfg.settle_band}) begin
         settle_t_in = (settle_sum > {1'b0, TIMER_MAX}) ? TIMER_MAX
                                                        : settle_sum[TIMER_W-1:0];
      end else begin
         settle_t_in = '0;
      end
      run_t_in = (run_sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : run_sum[TIMER_W-1:0];

      data_in.error   = error_in;
      data_in.diff    = {error_in[ERR_W-1], error_in} - {last_base[ERR_W-1], last_base};
      data_in.acc     = acc_in;
      data_in.settled = (settle_t_in > {1'b0, cfg.settle_limit_ms}) ||
                        ((cfg.timeout_ms != '0) && (run_t_in > {1'b0, cfg.timeout_ms}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         last_ff     <= '0;
         settle_t_ff <= '0;
         run_t_ff    <= '0;
         valid_ff    <= 1'b0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (accept) begin
            acc_ff      <= acc_in;
            last_ff     <= last_in;
            settle_t_ff <= settle_t_in;
            run_t_ff    <= run_t_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/psd_math.sv =====
// Gain multiplies, sum, floor and clamp; three register stages.
module psd_math (
   input  logic                            clock,
   input  logic                            reset,
   input  psd_pkg::cfg_type                cfg,
   input  logic                            in_valid,
   input  psd_pkg::front_data_type         in_data,
   output logic                            in_ready,
   output logic                            out_valid,
   output logic signed [psd_pkg::DRIVE_W-1:0] out_drive,
   output logic                            out_settled,
   input  logic                            out_ready
);
   import psd_pkg::*;

   localparam int PP_W = ERR_W + GAIN_W + 1;
   localparam int PD_W = DIFF_W + GAIN_W + 1;
   localparam int PL_W = ACC_LO_W + GAIN_W;
   localparam int PH_W = (ACC_W - ACC_LO_W) + GAIN_W + 1;

   // multiply stage
   logic                   mul_valid_ff;
   logic signed [PP_W-1:0] prod_p_ff, prod_p_in;
   logic signed [PD_W-1:0] prod_d_ff, prod_d_in;
   logic [PL_W-1:0]        prod_lo_ff, prod_lo_in;
   logic signed [PH_W-1:0] prod_hi_ff, prod_hi_in;
   logic                   mul_settled_ff;

   // sum stage
   logic                    sum_valid_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    sum_settled_ff;

   // result register
   logic                      rsp_valid_ff;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;
   logic                      settled_ff;

   logic                    out_free, sum_free;
   logic signed [SUM_W-1:0] quot;

   assign out_free = !rsp_valid_ff || out_ready;
   assign sum_free = !sum_valid_ff || out_free;
   assign in_ready = !mul_valid_ff || sum_free;

   assign out_valid   = rsp_valid_ff;
   assign out_drive   = drive_ff;
   assign out_settled = settled_ff;

   always_comb begin
      prod_p_in  = $signed({1'b0, cfg.gain_p}) * in_data.error;
      prod_d_in  = $signed({1'b0, cfg.gain_d}) * in_data.diff;
      prod_lo_in = cfg.gain_i * in_data.acc[ACC_LO_W-1:0];
      prod_hi_in = $signed({1'b0, cfg.gain_i}) * $signed(in_data.acc[ACC_W-1:ACC_LO_W]);

      sum_in = SUM_W'(prod_p_ff) + SUM_W'(prod_d_ff)
             + SUM_W'($signed({1'b0, prod_lo_ff}))
             + SUM_W'($signed({prod_hi_ff, {ACC_LO_W{1'b0}}}));

      // floor toward minus infinity, then clamp
      quot = sum_ff >>> FRAC_W;
      if (quot > SUM_W'(DRIVE_LIMIT)) begin
         drive_in = DRIVE_LIMIT;
      end else if (quot < -SUM_W'(DRIVE_LIMIT)) begin
         drive_in = -DRIVE_LIMIT;
      end else begin
         drive_in = quot[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            mul_valid_ff <= in_valid;
         end
         if (sum_free) begin
            sum_valid_ff <= mul_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_p_ff      <= prod_p_in;
         prod_d_ff      <= prod_d_in;
         prod_lo_ff     <= prod_lo_in;
         prod_hi_ff     <= prod_hi_in;
         mul_settled_ff <= in_data.settled;
      end
      if (sum_free && mul_valid_ff) begin
         sum_ff         <= sum_in;
         sum_settled_ff <= mul_settled_ff;
      end
      if (out_free && sum_valid_ff) begin
         drive_ff   <= drive_in;
         settled_ff <= sum_settled_ff;
      end
   end

endmodule

// ===== hdl/pid_step_with_settle_detect_core.sv =====
// Top level of the gated-integral PID step with settle detection.
//
//   channel   role    accepted when          carries
//   req_bus   sink    valid && ready         error_in (s24 Q16.8), clear
//   rsp_bus   source  valid && ready         drive (s16 Q8.8), settled
//   csr_bus   sink    valid (ready held 1)   index (3b), data (32b, masked)
//
// One request per cycle sustained while responses are taken; each response passes the
// front register, multiply, sum and clamp/result register in that order.
// Controller state (integral, last error, timers) updates in the cycle the
// request is taken, so consecutive requests need no spacing.
// The gain_i x integral product is split into two 16x20 partial products that
// are recombined in the sum stage.
// Reset (synchronous, active high) clears state, config registers and all valid flags.
// A stalled response holds its stage; upstream stages keep filling their
// bubbles, so requests are still taken until all four registers are full.
module pid_step_with_settle_detect_core #(
   parameter int TICK_MS = 10
) (
   input logic      clock,
   input logic      reset,
   psd_req_if.sink  req_bus,
   psd_rsp_if.source rsp_bus,
   psd_csr_if.sink  csr_bus
);
   import psd_pkg::*;

   cfg_type        cfg;
   logic           front_valid;
   logic           front_ready;
   front_data_type front_data;

   // register bank
   psd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .wr_ready (csr_bus.ready),
      .cfg      (cfg)
   );

   // state update: gating, sign-crossing clear, timers, settled flag
   psd_front #(
      .TICK_MS (TICK_MS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_bus.valid),
      .error_in  (req_bus.error_in),
      .clear     (req_bus.clear),
      .in_ready  (req_bus.ready),
      .out_valid (front_valid),
      .out_data  (front_data),
      .out_ready (front_ready)
   );

   // drive arithmetic
   psd_math u_math (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (front_valid),
      .in_data     (front_data),
      .in_ready    (front_ready),
      .out_valid   (rsp_bus.valid),
      .out_drive   (rsp_bus.drive),
      .out_settled (rsp_bus.settled),
      .out_ready   (rsp_bus.ready)
   );

endmodule

// ===== hdl/psd_checker.sv =====
// Port-level checks for the PID core, bound to the top level.
module psd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [psd_pkg::DRIVE_W-1:0] rsp_drive,
   input logic                           rsp_settled
);
   import psd_pkg::*;

   logic [2:0] inflight_ff, inflight_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_take && !rsp_take) begin
         inflight_in = inflight_ff + 3'd1;
      end else if (!req_take && rsp_take) begin
         inflight_in = inflight_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // no more than the four pipeline registers hold
   assert property (@(posedge clock) disable iff (reset) inflight_ff <= 3'd4)
      else $error("more requests in flight than pipeline stages");

   // a response needs a request behind it
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> inflight_ff != 3'd0)
      else $error("response without outstanding request");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> (rsp_drive <= DRIVE_LIMIT) && (rsp_drive >= -DRIVE_LIMIT))
      else $error("drive outside clamp range");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive)
                    && $stable(rsp_settled))
      else $error("stalled response changed");

endmodule

bind pid_step_with_settle_detect_core psd_checker u_psd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_drive   (rsp_bus.drive),
   .rsp_settled (rsp_bus.settled)
);

// ===== bench/psd_drive_checker.sv =====
`timescale 1ns / 100ps
// Watches the PID step channels, predicts every response and compares it.
module psd_drive_checker #(
   parameter int TICK_MS = 10
) (
   input  logic clock,
   input  logic reset,
   psd_req_if   req_bus,
   psd_rsp_if   rsp_bus,
   psd_csr_if   csr_bus,
   output int   failures,
   output int   pending,
   output int   checked
);
   import psd_pkg::*;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      settled;
   } drive_result_type;

   localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_LO = -(longint'(1) <<< (ACC_W - 1));

   cfg_type                 cfg;
   logic signed [ACC_W-1:0] integral_sum;
   logic signed [ERR_W-1:0] last_error;
   logic [TIMER_W-1:0]      settled_ms;
   logic [TIMER_W-1:0]      running_ms;
   drive_result_type        expected_drives[$];

   function automatic logic [TIMER_W-1:0] timer_tick(input logic [TIMER_W-1:0] t);
      int n;
      n = int'(t) + TICK_MS;
      return (n > int'(TIMER_MAX)) ? TIMER_MAX : n[TIMER_W-1:0];
   endfunction

   function automatic void write_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_GAIN_P:        cfg.gain_p          = value[GAIN_W-1:0];
         REG_GAIN_I:        cfg.gain_i          = value[GAIN_W-1:0];
         REG_GAIN_D:        cfg.gain_d          = value[GAIN_W-1:0];
         REG_INTEGRAL_GATE: cfg.integral_gate   = value[BAND_W-1:0];
         REG_SETTLE_BAND:   cfg.settle_band     = value[BAND_W-1:0];
         REG_SETTLE_LIMIT:  cfg.settle_limit_ms = value[MS_W-1:0];
         REG_TIMEOUT:       cfg.timeout_ms      = value[MS_W-1:0];
         default: ;
      endcase
   endfunction

   // One controller step: updates the state copy and returns the response.
   function automatic drive_result_type predict_drive(input logic signed [ERR_W-1:0] err,
                                                      input logic clr);
      longint           e;
      longint           mag;
      longint           acc;
      longint           le;
      longint           s;
      longint           d;
      drive_result_type res;
      e   = err;
      mag = (e < 0) ? -e : e;
      if (clr) begin
         integral_sum = '0;
         last_error   = '0;
         settled_ms   = '0;
         running_ms   = '0;
      end
      acc = integral_sum;
      if (mag < longint'(cfg.integral_gate)) begin
         acc = acc + e;
         if (acc > ACC_HI) acc = ACC_HI;
         if (acc < ACC_LO) acc = ACC_LO;
      end
      le = last_error;
      // zero on either side is not a crossing
      if ((e > 0 && le < 0) || (e < 0 && le > 0)) acc = 0;
      integral_sum = acc[ACC_W-1:0];
      s = longint'(cfg.gain_p) * e + longint'(cfg.gain_i) * acc
        + longint'(cfg.gain_d) * (e - le);
      d = s >>> FRAC_W;
      if (d > longint'(DRIVE_LIMIT)) d = DRIVE_LIMIT;
      if (d < -longint'(DRIVE_LIMIT)) d = -longint'(DRIVE_LIMIT);
      last_error = err;
      if (mag < longint'(cfg.settle_band)) settled_ms = timer_tick(settled_ms);
      else settled_ms = '0;
      running_ms  = timer_tick(running_ms);
      res.drive   = d[DRIVE_W-1:0];
      res.settled = (settled_ms > cfg.settle_limit_ms) ||
                    (cfg.timeout_ms != '0 && running_ms > cfg.timeout_ms);
      return res;
   endfunction

   always @(posedge clock) begin
      drive_result_type want;
      if (reset) begin
         cfg          = '0;
         integral_sum = '0;
         last_error   = '0;
         settled_ms   = '0;
         running_ms   = '0;
         expected_drives.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) write_register(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready)
            expected_drives.push_back(predict_drive(req_bus.error_in, req_bus.clear));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_drives.size() == 0) begin
               failures++;
               $display("%0t: response with none outstanding: expected nothing, got drive %0d settled %0b",
                        $time, rsp_bus.drive, rsp_bus.settled);
            end else begin
               want = expected_drives.pop_front();
               checked++;
               if (rsp_bus.drive !== want.drive) begin
                  failures++;
                  $display("%0t: drive mismatch: expected %0d, got %0d",
                           $time, want.drive, rsp_bus.drive);
               end
               if (rsp_bus.settled !== want.settled) begin
                  failures++;
                  $display("%0t: settled mismatch: expected %0b, got %0b",
                           $time, want.settled, rsp_bus.settled);
               end
            end
         end
      end
      pending = expected_drives.size();
   end

endmodule

// ===== bench/pid_step_with_settle_detect_core_test.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the PID step with settle detection; checking sits in the checker.
module pid_step_with_settle_detect_core_test;
   import psd_pkg::*;

   localparam int TICK_MS         = 10;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = 12;      // pipe is four deep, allow a margin
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int PHASE_ITEMS     = 96;
   localparam int SOAK_ITEMS      = 30;      // full-scale same-sign run per polarity

   // index past the end of the register list, must be ignored
   localparam logic [CSR_IDX_W-1:0]    REG_UNUSED = 3'd7;
   localparam logic signed [ERR_W-1:0] ERR_MAX    = 24'sh7FFFFF;
   localparam logic signed [ERR_W-1:0] ERR_MIN    = 24'sh800000;

   typedef enum int {SET_MODERATE, SET_ALL_MAX, SET_ALL_ZERO, SET_WIDE} settings_style_type;
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_pattern_type;

   logic clock;
   logic reset;

   psd_req_if req_bus ();
   psd_rsp_if rsp_bus ();
   psd_csr_if csr_bus ();

   int failures;
   int pending;
   int checked;

   int  req_idle_pct  = 0;    // chance per cycle that the sender sits idle
   int  rsp_stall_pct = 0;    // chance per cycle that the receiver drops ready
   bit  hold_request  = 1'b0; // asks the receiver for one long hold-off
   int  requests_sent = 0;
   int  reg_writes    = 0;
   int  settings_run  = 0;

   logic signed [ERR_W-1:0] prev_err;  // last error sent, used for sign flips
   cfg_type                 cur;       // settings in force, steers the error picks

   pid_step_with_settle_detect_core #(
      .TICK_MS (TICK_MS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   psd_drive_checker #(
      .TICK_MS (TICK_MS)
   ) i_checker (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_bus  (csr_bus),
      .failures (failures),
      .pending  (pending),
      .checked  (checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("pid_step_with_settle_detect_core_test NOT OK");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off counted here on request.
   // While it holds off the sender keeps offering, so the pipe fills and the
   // block must drop req ready.
   initial begin : receiver
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic set_idling(input idle_pattern_type pattern);
      case (pattern)
         IDLE_NONE: begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            req_idle_pct  = 54;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            req_idle_pct  = 0;
            rsp_stall_pct = 54;
         end
         default: begin
            req_idle_pct  = 23;
            rsp_stall_pct = 23;
         end
      endcase
   endtask

   // All drive tasks are entered and left at a falling edge.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
      reg_writes++;
   endtask

   // Random junk above the field width checks that the block masks the write.
   function automatic logic [CSR_DATA_W-1:0] with_junk(input logic [CSR_DATA_W-1:0] field,
                                                       input int width);
      logic [CSR_DATA_W-1:0] mask;
      mask = '1;
      mask = mask >> (CSR_DATA_W - width);
      return (field & mask) | ($urandom() & ~mask);
   endfunction

   task automatic load_settings(input cfg_type c);
      write_reg(REG_GAIN_P,        with_junk(c.gain_p, GAIN_W));
      write_reg(REG_GAIN_I,        with_junk(c.gain_i, GAIN_W));
      write_reg(REG_GAIN_D,        with_junk(c.gain_d, GAIN_W));
      write_reg(REG_INTEGRAL_GATE, with_junk(c.integral_gate, BAND_W));
      write_reg(REG_SETTLE_BAND,   with_junk(c.settle_band, BAND_W));
      write_reg(REG_SETTLE_LIMIT,  with_junk(c.settle_limit_ms, MS_W));
      write_reg(REG_TIMEOUT,       with_junk(c.timeout_ms, MS_W));
      cur = c;
      settings_run++;
   endtask

   // valid stays high from one request to the next unless an idle gap falls between
   task automatic send_request(input logic signed [ERR_W-1:0] err, input logic clr);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.error_in = err;
      req_bus.clear    = clr;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      requests_sent++;
      prev_err = err;
   endtask

   // Stop offering, let every outstanding response come back, then settle.
   task automatic wait_idle(input int extra);
      req_bus.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   function automatic cfg_type random_settings(input settings_style_type style);
      cfg_type c;
      case (style)
         SET_ALL_MAX:  c = '1;
         SET_ALL_ZERO: c = '0;
         SET_WIDE: begin
            c.gain_p          = GAIN_W'($urandom());
            c.gain_i          = GAIN_W'($urandom());
            c.gain_d          = GAIN_W'($urandom());
            c.integral_gate   = BAND_W'($urandom());
            c.settle_band     = BAND_W'($urandom());
            c.settle_limit_ms = MS_W'($urandom());
            c.timeout_ms      = MS_W'($urandom());
         end
         default: begin
            // gains around unity keep the drive mostly inside the clamp
            c.gain_p          = GAIN_W'($urandom_range(0, 1023));
            c.gain_i          = GAIN_W'($urandom_range(0, 255));
            c.gain_d          = GAIN_W'($urandom_range(0, 1023));
            c.integral_gate   = BAND_W'($urandom_range(0, 3000));
            c.settle_band     = BAND_W'($urandom_range(0, 3000));
            c.settle_limit_ms = MS_W'($urandom_range(0, 250));
            c.timeout_ms      = $urandom_range(1) ? 16'd0 : 16'($urandom_range(20, 600));
         end
      endcase
      return c;
   endfunction

   // Single noisy error: near zero, on the gate or band edge, a sign flip,
   // anything at all, zero, or a rail.
   function automatic logic signed [ERR_W-1:0] pick_error();
      int sel;
      int v;
      int boundary;
      sel = $urandom_range(99);
      if (sel < 30) begin
         v = int'($urandom_range(0, 8191)) - 4096;
      end else if (sel < 50) begin
         boundary = (sel < 40) ? int'(cur.integral_gate) : int'(cur.settle_band);
         v = boundary + int'($urandom_range(0, 4)) - 2;
         if ($urandom_range(1)) v = -v;
      end else if (sel < 65) begin
         v = -int'(prev_err) + int'($urandom_range(0, 6)) - 3;
      end else if (sel < 88) begin
         v = $urandom();
      end else if (sel < 94) begin
         v = 0;
      end else begin
         v = $urandom_range(1) ? int'(ERR_MAX) : int'(ERR_MIN);
      end
      return v[ERR_W-1:0];
   endfunction

   // Hand-picked steps: reset settings, gating, crossings, band edges,
   // settling, clear, rails and the floor rounding of negative sums.
   task automatic run_directed();
      cfg_type c;
      set_idling(IDLE_NONE);
      // registers at reset: drive zero, never settled
      send_request(24'sd1000, 1'b0);
      send_request(-24'sd1000, 1'b0);
      wait_idle(2);

      c                 = '0;
      c.gain_p          = 16'h0100;
      c.gain_i          = 16'h0040;
      c.gain_d          = 16'h0080;
      c.integral_gate   = 23'h000A00;
      c.settle_band     = 23'h000300;
      c.settle_limit_ms = 16'd20;
      load_settings(c);
      write_reg(REG_UNUSED, $urandom());   // out-of-range index, nothing may change
      send_request(24'sd0, 1'b0);
      send_request(24'sd256, 1'b0);        // accumulate
      send_request(24'sd512, 1'b0);
      send_request(24'sd0, 1'b0);          // zero does not count as a crossing
      send_request(-24'sd256, 1'b0);       // from zero: still no crossing
      send_request(24'sd256, 1'b0);        // real crossing, integral cleared
      send_request(24'sd2559, 1'b0);       // just inside the gate
      send_request(24'sd2560, 1'b0);       // on the gate: no accumulate
      send_request(24'sd767, 1'b0);        // just inside the settle band
      send_request(24'sd768, 1'b0);        // on the band: settle timer restarts
      repeat (4) send_request(24'sd100, 1'b0);   // settle time passes its limit
      send_request(24'sd100, 1'b1);        // clear before the step
      send_request(ERR_MAX, 1'b0);
      send_request(ERR_MIN, 1'b0);         // full-scale difference, clamps low
      send_request(ERR_MIN, 1'b0);
      send_request(-24'sd1, 1'b0);
      send_request(24'sd1, 1'b0);
      wait_idle(2);

      // unit LSB gain: drive is the sum shifted down, rounded toward minus infinity
      c        = '0;
      c.gain_p = 16'd1;
      load_settings(c);
      send_request(-24'sd1, 1'b0);
      send_request(-24'sd256, 1'b0);
      send_request(-24'sd257, 1'b0);
      send_request(24'sd255, 1'b0);
      send_request(24'sd256, 1'b0);
      wait_idle(2);
   endtask

   // Mostly runs of small same-sign errors that let the settle timer build,
   // with the odd sign flip and clear; the rest single noisy picks.
   task automatic run_random_phase(input settings_style_type style,
                                   input idle_pattern_type pattern,
                                   input int n_items, input bit squeeze);
      int  sent;
      int  run_len;
      int  k;
      int  mag;
      bit  neg;
      bit  clr;
      logic signed [ERR_W-1:0] e;
      load_settings(random_settings(style));
      set_idling(pattern);
      if (squeeze) hold_request = 1'b1;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 60) begin
            run_len = $urandom_range(3, 25);
            neg     = 1'($urandom_range(1));
            clr     = ($urandom_range(99) < 15);
            for (k = 0; k < run_len && sent < n_items; k++) begin
               mag = $urandom_range(0, 1500);
               if ($urandom_range(99) < 8) neg = !neg;
               e = ERR_W'(neg ? -mag : mag);
               send_request(e, clr || ($urandom_range(99) < 2));
               clr = 1'b0;
               sent++;
            end
         end else begin
            send_request(pick_error(), $urandom_range(99) < 4);
            sent++;
         end
      end
      wait_idle(2);
   endtask

   // Same-sign run at near full-scale error with everything wide open: the
   // integral grows by almost its largest step each request and the timers
   // count on. A bad sign extension or carry would show up as a flipped drive.
   task automatic run_saturation_soak(input bit negative);
      cfg_type c;
      int      k;
      int      v;
      c                 = '0;
      c.gain_i          = 16'd1;
      c.integral_gate   = '1;
      c.settle_band     = '1;
      c.settle_limit_ms = '1;
      c.timeout_ms      = '1;
      load_settings(c);
      set_idling(IDLE_NONE);
      for (k = 0; k < SOAK_ITEMS; k++) begin
         v = $urandom_range(8388600, 8388606);
         if (negative) v = -v;
         send_request(v[ERR_W-1:0], k == 0);
      end
      wait_idle(2);
   endtask

   initial begin : stimulus
      settings_style_type plan [8];
      int p;
      plan = '{SET_MODERATE, SET_ALL_MAX, SET_MODERATE, SET_WIDE,
               SET_MODERATE, SET_ALL_ZERO, SET_WIDE, SET_MODERATE};
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.error_in = '0;
      req_bus.clear    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;
      prev_err         = '0;
      cur              = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      run_directed();

      // settings and idling change together; phase four carries the long hold-off
      for (p = 0; p < 8; p++)
         run_random_phase(plan[p], idle_pattern_type'(p % 4), PHASE_ITEMS, p == 4);

      run_saturation_soak(1'b0);
      run_saturation_soak(1'b1);

      wait_idle(DRAIN_CYCLES);

      $display("Covered %0d requests under %0d settings (%0d register writes),",
               requests_sent, settings_run, reg_writes);
      $display("all idling mixes, a long response hold-off and full-scale runs; %0d compared.",
               checked);
      if (pending != 0)
         $display("%0t: responses missing: expected %0d more, got none", $time, pending);
      if (failures == 0 && pending == 0) begin
         $display("pid_step_with_settle_detect_core_test OK");
      end else begin
         $display("pid_step_with_settle_detect_core_test NOT OK");
      end
      $finish;
   end

endmodule
